// File: rtl/cdmrs_pkg.sv
// Shared types and constants for the consecutive draw match run monitor.
// Used by cdmrs_match, cdmrs_stats and the top level; no dependencies.
`default_nettype none

package cdmrs_pkg;

  localparam int unsigned IdW = 64;
  localparam int unsigned CntW = 64;
  localparam int unsigned RunW = 32;
  localparam int unsigned InDataW = 3 * IdW;
  localparam int unsigned OutDataW = 6 * CntW + RunW;

  localparam logic [RunW-1:0] RunMin = RunW'(2);
  localparam logic [RunW-1:0] RunStart = RunW'(1);

  localparam logic CmdDraw = 1'b0;
  localparam logic CmdSnap = 1'b1;

  typedef struct packed {
    logic ss;
    logic ssm;
    logic ssg;
  } match_t;

  typedef struct packed {
    logic [CntW-1:0] completed_runs;
    logic [RunW-1:0] run_length_max;
    logic [CntW-1:0] run_length_sum;
    logic [CntW-1:0] same_all_count;
    logic [CntW-1:0] same_shader_material_count;
    logic [CntW-1:0] same_shader_count;
    logic [CntW-1:0] draw_count;
  } stats_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (&v) ? v : v + CntW'(1);
  endfunction

endpackage

`default_nettype wire

// File: rtl/cdmrs_match.sv
// Previous draw id store and comparison against the draw being taken.
// Depends on cdmrs_pkg.
`default_nettype none

module cdmrs_match
  import cdmrs_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           take,
  input  wire logic [IdW-1:0] shader_id,
  input  wire logic [IdW-1:0] material_id,
  input  wire logic [IdW-1:0] geometry_id,
  output match_t              flags
);

  logic [IdW-1:0] prev_shader;
  logic [IdW-1:0] prev_material;
  logic [IdW-1:0] prev_geometry;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_shader   <= '0;
      prev_material <= '0;
      prev_geometry <= '0;
    end else if (take) begin
      prev_shader   <= shader_id;
      prev_material <= material_id;
      prev_geometry <= geometry_id;
    end
  end

  always_comb begin
    flags.ss  = (shader_id == prev_shader) && (shader_id != '0);
    flags.ssm = flags.ss && (material_id == prev_material);
    flags.ssg = flags.ssm && (geometry_id == prev_geometry) && (geometry_id != '0);
  end

endmodule

`default_nettype wire

// File: rtl/cdmrs_stats.sv
// Window counters and run tracking with saturation; snapshot clears the window.
// Depends on cdmrs_pkg.
`default_nettype none

module cdmrs_stats
  import cdmrs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   take,
  input  wire logic   snap,
  input  wire match_t flags,
  output stats_t      view
);

  stats_t          win;
  stats_t          win_next;
  logic [RunW-1:0] current_run;
  logic [RunW-1:0] current_run_next;
  logic [CntW:0]   sum_wide;

  always_comb begin
    win_next         = win;
    current_run_next = current_run;
    sum_wide         = {1'b0, win.run_length_sum} + {1'b0, CntW'(current_run)};
    if (take) begin
      win_next.draw_count = sat_inc(win.draw_count);
      if (flags.ss) begin
        win_next.same_shader_count = sat_inc(win.same_shader_count);
      end
      if (flags.ssm) begin
        win_next.same_shader_material_count = sat_inc(win.same_shader_material_count);
      end
      if (flags.ssg) begin
        win_next.same_all_count = sat_inc(win.same_all_count);
        if (!(&current_run)) begin
          current_run_next = current_run + RunW'(1);
        end
      end else begin
        if (current_run >= RunMin) begin
          win_next.run_length_sum = sum_wide[CntW] ? '1 : sum_wide[CntW-1:0];
          win_next.completed_runs = sat_inc(win.completed_runs);
          if (current_run > win.run_length_max) begin
            win_next.run_length_max = current_run;
          end
        end
        current_run_next = RunStart;
      end
    end
  end

  assign view = win_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      win         <= '0;
      current_run <= '0;
    end else begin
      current_run <= current_run_next;
      win         <= snap ? '0 : win_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/consecutive_draw_match_run_stats.sv
// Consecutive draw match run monitor, top level. Depends on cdmrs_pkg,
// cdmrs_match and cdmrs_stats.
// Result path: the input transfer is captured in the input register, and the result in the result register.
// Throughput: one item per cycle while m_tready is high; a stalled result holds off new input.
// Reset (rst, synchronous): clears enable, previous ids, run in progress and counters.
`default_nettype none

module consecutive_draw_match_run_stats
  import cdmrs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,
  input  wire logic                s_tvalid,
  output      logic                s_tready,
  input  wire logic [InDataW-1:0]  s_tdata,  // shader_id, material_id, geometry_id
  input  wire logic                s_tuser,  // cmd
  output      logic                m_tvalid,
  input  wire logic                m_tready,
  output      logic [OutDataW-1:0] m_tdata   // draw_count, same_shader_count,
                                             // same_shader_material_count, same_all_count,
                                             // run_length_sum, run_length_max, completed_runs
);

  logic             enable;
  logic             in_valid;
  logic             in_cmd;
  logic [IdW-1:0]   in_shader;
  logic [IdW-1:0]   in_material;
  logic [IdW-1:0]   in_geometry;
  logic             out_valid;
  stats_t           out_data;
  logic             advance;
  logic             take;
  logic             snap;
  match_t           flags;
  stats_t           view;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign take     = advance && (in_cmd == CmdDraw) && enable;
  assign snap     = advance && (in_cmd == CmdSnap);
  assign s_tready = !in_valid || !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_we) begin
      enable <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd      <= s_tuser;
      in_shader   <= s_tdata[IdW-1:0];
      in_material <= s_tdata[2*IdW-1:IdW];
      in_geometry <= s_tdata[3*IdW-1:2*IdW];
    end
  end

  cdmrs_match u_match (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .shader_id   (in_shader),
    .material_id (in_material),
    .geometry_id (in_geometry),
    .flags       (flags)
  );

  cdmrs_stats u_stats (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .snap  (snap),
    .flags (flags),
    .view  (view)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= view;
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_consecutive_draw_match_run_stats.sv
`timescale 1ns / 1ps
// Self-checking bench for the consecutive draw match run monitor.
// A directed table and random draw streams are checked against an in-bench window model.
// Depends on cdmrs_pkg and consecutive_draw_match_run_stats.

module tb_consecutive_draw_match_run_stats;
  import cdmrs_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles = 300;
  localparam int HoldAfter = 400;
  localparam int SettleCycles = 6;
  localparam int Phases = 5;
  localparam logic [IdW-1:0] IdOnes = '1;
  localparam logic [IdW-1:0] IdNull = '0;
  localparam logic [IdW-1:0] AltA = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [IdW-1:0] Alt5 = 64'h5555_5555_5555_5555;
  localparam logic PhaseEn [Phases] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam int PhaseLen [Phases] = '{410, 40, 410, 40, 410};

  typedef struct {
    logic en;
    logic cmd;
    logic [IdW-1:0] sh;
    logic [IdW-1:0] ma;
    logic [IdW-1:0] ge;
    logic typed;
    stats_t want;
  } row_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;   // shader_id, material_id, geometry_id
  logic s_tuser = 1'b0;               // cmd
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;       // draw_count, same_shader_count,
                                      // same_shader_material_count, same_all_count,
                                      // run_length_sum, run_length_max, completed_runs

  consecutive_draw_match_run_stats DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  stats_t stats_due [$];
  row_t plan [$];

  stats_t win = '0;
  logic model_en = 1'b0;
  logic [IdW-1:0] seen_shader = '0;
  logic [IdW-1:0] seen_material = '0;
  logic [IdW-1:0] seen_geometry = '0;
  logic [RunW-1:0] run_len = '0;

  int errors = 0;
  int checked = 0;
  int draws_taken = 0;
  int snaps_sent = 0;
  int runs_closed = 0;
  int longest_run = 0;
  int send_idle_pct = 20;
  int take_idle_pct = 20;
  int burst_left = 0;
  logic [IdW-1:0] last_sh = '0;
  logic [IdW-1:0] last_ma = '0;
  logic [IdW-1:0] last_ge = '0;
  logic [IdW-1:0] pool_a;
  logic [IdW-1:0] pool_b;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] v);
    return (&v) ? v : v + CntW'(1);
  endfunction

  function automatic logic [CntW-1:0] add_clamped(input logic [CntW-1:0] a,
                                                  input logic [CntW-1:0] b);
    logic [CntW:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[CntW] ? '1 : total[CntW-1:0];
  endfunction

  // Advance the window model by one item and return the counters it reports.
  function automatic stats_t window_after(input logic cmd, input logic [IdW-1:0] sh,
                                          input logic [IdW-1:0] ma, input logic [IdW-1:0] ge);
    stats_t rep;
    logic hit_sh;
    logic hit_mat;
    logic hit_all;
    if (cmd == CmdSnap) begin
      rep = win;
      win = '0;
      return rep;
    end
    if (model_en) begin
      hit_sh = (sh == seen_shader) && (sh != IdNull);
      hit_mat = hit_sh && (ma == seen_material);
      hit_all = hit_mat && (ge == seen_geometry) && (ge != IdNull);
      win.draw_count = bump(win.draw_count);
      if (hit_sh) win.same_shader_count = bump(win.same_shader_count);
      if (hit_mat) win.same_shader_material_count = bump(win.same_shader_material_count);
      if (hit_all) win.same_all_count = bump(win.same_all_count);
      if (hit_all) begin
        if (!(&run_len)) run_len = run_len + RunW'(1);
      end else begin
        if (run_len >= RunMin) begin
          win.run_length_sum = add_clamped(win.run_length_sum, CntW'(run_len));
          win.completed_runs = bump(win.completed_runs);
          if (run_len > win.run_length_max) win.run_length_max = run_len;
          runs_closed++;
          if (int'(run_len) > longest_run) longest_run = int'(run_len);
        end
        run_len = RunStart;
      end
      seen_shader = sh;
      seen_material = ma;
      seen_geometry = ge;
      draws_taken++;
    end
    return win;
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 45;
    endcase
  endfunction

  function automatic logic [IdW-1:0] pool_id();
    case ($urandom_range(0, 5))
      0: return IdNull;
      1: return IdOnes;
      2: return 64'd1;
      3: return pool_a;
      4: return pool_b;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void row(input logic en, input logic cmd, input logic [IdW-1:0] sh,
                              input logic [IdW-1:0] ma, input logic [IdW-1:0] ge,
                              input logic typed, input stats_t want);
    row_t r;
    r.en = en;
    r.cmd = cmd;
    r.sh = sh;
    r.ma = ma;
    r.ge = ge;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endfunction

  task automatic put_item(input logic cmd, input logic [IdW-1:0] sh, input logic [IdW-1:0] ma,
                          input logic [IdW-1:0] ge, input logic typed, input stats_t want);
    int gap;
    stats_t pred;
    gap = pick_gap(send_idle_pct);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {ge, ma, sh};
    do @(posedge clk); while (!s_tready);
    pred = window_after(cmd, sh, ma, ge);
    stats_due.push_back(typed ? want : pred);
    if (cmd == CmdSnap) snaps_sent++;
  endtask

  // Drain the block, then write the enable register.
  task automatic set_enable(input logic v);
    s_tvalid <= 1'b0;
    while (stats_due.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_en = v;
  endtask

  task automatic random_phase(input int count);
    int r;
    logic [IdW-1:0] sh;
    logic [IdW-1:0] ma;
    logic [IdW-1:0] ge;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) == 0) send_idle_pct = pick_pct();
      if ($urandom_range(0, 99) < 4) begin
        put_item(CmdSnap, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 1'b0, '0);
        continue;
      end
      sh = last_sh;
      ma = last_ma;
      ge = last_ge;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          burst_left = $urandom_range(10, 80);
        end else if (r < 40) begin
          // repeat the previous draw as it is
        end else if (r < 55) begin
          ge = pool_id();
        end else if (r < 65) begin
          ma = pool_id();
        end else if (r < 90) begin
          sh = pool_id();
          ma = pool_id();
          ge = pool_id();
        end else begin
          sh = {$urandom, $urandom};
          ma = {$urandom, $urandom};
          ge = {$urandom, $urandom};
        end
      end
      last_sh = sh;
      last_ma = ma;
      last_ge = ge;
      put_item(CmdDraw, sh, ma, ge, 1'b0, '0);
    end
  endtask

  task automatic cmp_field(input string label, input logic [CntW-1:0] want,
                           input logic [CntW-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  task automatic check_result(input stats_t got);
    stats_t want;
    checked++;
    if (stats_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got draw_count %0d",
               $time, got.draw_count);
      return;
    end
    want = stats_due.pop_front();
    cmp_field("draw_count", want.draw_count, got.draw_count);
    cmp_field("same_shader_count", want.same_shader_count, got.same_shader_count);
    cmp_field("same_shader_material_count", want.same_shader_material_count,
              got.same_shader_material_count);
    cmp_field("same_all_count", want.same_all_count, got.same_all_count);
    cmp_field("run_length_sum", want.run_length_sum, got.run_length_sum);
    cmp_field("run_length_max", CntW'(want.run_length_max), CntW'(got.run_length_max));
    cmp_field("completed_runs", want.completed_runs, got.completed_runs);
  endtask

  // Result side: random back-pressure plus one long hold-off.
  initial begin
    int gap;
    logic held_off;
    held_off = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) == 0) take_idle_pct = pick_pct();
      gap = pick_gap(take_idle_pct);
      if (!held_off && checked >= HoldAfter) begin
        gap = HoldCycles;
        held_off = 1'b1;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_result(stats_t'(m_tdata));
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("consecutive_draw_match_run_stats: mismatch");
        $finish;
      end
    end
  end

  initial begin
    stats_t one_draw;
    pool_a = {$urandom, $urandom};
    pool_b = {$urandom, $urandom};
    one_draw = '0;
    one_draw.draw_count = CntW'(1);

    // disabled draws are ignored; snapshot after reset reports zeros
    row(1'b0, CmdDraw, IdOnes, IdOnes, IdOnes, 1'b1, '0);
    row(1'b0, CmdSnap, IdOnes, IdOnes, IdOnes, 1'b1, '0);
    // null shader never matches, even against the null reset ids
    row(1'b1, CmdDraw, IdNull, IdNull, IdNull, 1'b1, one_draw);
    row(1'b1, CmdDraw, IdNull, IdNull, IdNull, 1'b0, '0);
    row(1'b1, CmdDraw, IdOnes, IdOnes, IdOnes, 1'b0, '0);
    row(1'b1, CmdDraw, IdOnes, IdOnes, IdOnes, 1'b0, '0);
    row(1'b1, CmdDraw, IdOnes, IdOnes, IdOnes, 1'b0, '0);
    // null geometry breaks the run and never counts as a full match
    row(1'b1, CmdDraw, IdOnes, IdOnes, IdNull, 1'b0, '0);
    row(1'b1, CmdDraw, IdOnes, IdOnes, IdNull, 1'b0, '0);
    row(1'b1, CmdDraw, IdOnes, 64'd5, IdNull, 1'b0, '0);
    row(1'b1, CmdSnap, AltA, Alt5, IdOnes, 1'b0, '0);
    row(1'b1, CmdDraw, IdOnes, 64'd5, 64'd7, 1'b0, '0);
    row(1'b1, CmdDraw, IdOnes, 64'd5, 64'd7, 1'b0, '0);
    row(1'b1, CmdDraw, 64'd1, 64'd5, 64'd7, 1'b0, '0);
    // disabled: ids are not taken, snapshot still reports and clears
    row(1'b0, CmdDraw, IdOnes, IdOnes, IdOnes, 1'b0, '0);
    row(1'b0, CmdSnap, IdNull, IdNull, IdNull, 1'b0, '0);
    row(1'b1, CmdDraw, 64'd1, 64'd5, 64'd7, 1'b0, '0);
    row(1'b1, CmdDraw, 64'd1, 64'd5, 64'd7, 1'b0, '0);
    // run in progress survives a snapshot
    row(1'b1, CmdSnap, IdOnes, IdOnes, IdOnes, 1'b0, '0);
    row(1'b1, CmdDraw, 64'd1, 64'd5, 64'd7, 1'b0, '0);
    row(1'b1, CmdDraw, 64'd2, 64'd5, 64'd7, 1'b0, '0);
    row(1'b1, CmdDraw, AltA, Alt5, AltA, 1'b0, '0);
    row(1'b1, CmdDraw, AltA, Alt5, AltA, 1'b0, '0);
    row(1'b1, CmdDraw, Alt5, AltA, Alt5, 1'b0, '0);
    row(1'b1, CmdSnap, Alt5, AltA, Alt5, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].en != model_en) set_enable(plan[i].en);
      put_item(plan[i].cmd, plan[i].sh, plan[i].ma, plan[i].ge, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < Phases; p++) begin
      if (PhaseEn[p] != model_en) set_enable(PhaseEn[p]);
      random_phase(PhaseLen[p]);
    end

    s_tvalid <= 1'b0;
    while (stats_due.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Covered %0d counted draws and %0d snapshots over enabled and disabled phases,",
             draws_taken, snaps_sent);
    $display("%0d runs of two or more closed (longest %0d), %0d results checked.",
             runs_closed, longest_run, checked);
    if (errors == 0) begin
      $display("consecutive_draw_match_run_stats: match");
    end else begin
      $display("consecutive_draw_match_run_stats: mismatch");
    end
    $finish;
  end

endmodule
